// ===== src/midi_byte_stream_parser_unit_defines.svh =====
// assertion macros for the midi byte stream parser
`ifndef MIDI_BYTE_STREAM_PARSER_UNIT_DEFINES_SVH
`define MIDI_BYTE_STREAM_PARSER_UNIT_DEFINES_SVH

// check holds in the same cycle as the trigger
`define MBSP_ASSERT_NOW(label, trig, check, text) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (check)) \
    else $error(text);

// check holds in the cycle after the trigger
`define MBSP_ASSERT_NEXT(label, trig, check, text) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (check)) \
    else $error(text);

`endif

// ===== src/mbsp_pkg.sv =====
// types, codes and helpers shared by the midi byte stream parser
package mbsp_pkg;

  localparam logic [7:0] ACTIVE_SENSE = 8'hFE;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_END    = 8'hF7;
  localparam logic [7:0] MTC_QF       = 8'hF1;
  localparam logic [7:0] SONG_POS     = 8'hF2;
  localparam logic [7:0] SONG_SEL     = 8'hF3;
  localparam logic [7:0] STATUS_BIT   = 8'h80;
  localparam logic [3:0] SYSTEM_NIB   = 4'hF;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_DATA  = 3'b010,
    MODE_SYSEX = 3'b100
  } mode_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
    logic [1:0] byte_count;
  } msg_t;

  // data bytes that follow a channel status
  function automatic logic [1:0] channel_data_len(input logic [7:0] status);
    logic [2:0] hi;
    hi = status[6:4];
    return (hi == 3'd4 || hi == 3'd5) ? 2'd1 : 2'd2;
  endfunction

endpackage

// ===== src/mbsp_byte_if.sv =====
// valid/ready channel carrying one received midi byte
interface mbsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/mbsp_msg_if.sv =====
// valid/ready channel carrying one assembled midi message
interface mbsp_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [7:0] first_data;
  logic [7:0] second_data;
  logic [1:0] byte_count;

  modport source (output valid, output status_byte, output first_data,
                  output second_data, output byte_count, input ready);
  modport sink   (input valid, input status_byte, input first_data,
                  input second_data, input byte_count, output ready);
endinterface

// ===== src/mbsp_parse.sv =====
// parser state and per-byte message assembly logic
module mbsp_parse import mbsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output msg_t       res
);

  mode_t      mode, mode_next;
  logic [1:0] held, held_next;
  logic [1:0] remaining, remaining_next;
  logic [7:0] running, running_next;
  logic [7:0] store [0:2];
  logic [7:0] store_next [0:2];
  logic [1:0] count;
  logic [1:0] len;

  always_comb begin
    mode_next      = mode;
    held_next      = held;
    remaining_next = remaining;
    running_next   = running;
    store_next     = store;
    res_valid      = 1'b0;
    count          = 2'd1;
    len            = channel_data_len(running);
    if (rx_byte != ACTIVE_SENSE) begin
      unique case (mode)
        MODE_IDLE: begin
          if (rx_byte[7]) begin
            if (rx_byte[7:4] == SYSTEM_NIB) begin
              case (rx_byte) inside
                SYSEX_START: begin
                  mode_next = MODE_SYSEX;
                end
                MTC_QF, SONG_POS, SONG_SEL: begin
                  mode_next      = MODE_DATA;
                  store_next[0]  = rx_byte;
                  held_next      = 2'd1;
                  remaining_next = (rx_byte == SONG_POS) ? 2'd2 : 2'd1;
                end
                default: begin
                  store_next[0]  = rx_byte;
                  held_next      = 2'd0;
                  remaining_next = 2'd0;
                  res_valid      = 1'b1;
                  count          = 2'd1;
                end
              endcase
            end else begin
              mode_next      = MODE_DATA;
              store_next[0]  = rx_byte;
              running_next   = rx_byte;
              held_next      = 2'd1;
              remaining_next = channel_data_len(rx_byte);
            end
          end else if ((running & STATUS_BIT) != 8'h00) begin
            store_next[0] = running;
            store_next[1] = rx_byte;
            if (len <= 2'd1) begin
              held_next      = 2'd0;
              remaining_next = 2'd0;
              res_valid      = 1'b1;
              count          = 2'd2;
            end else begin
              mode_next      = MODE_DATA;
              held_next      = 2'd2;
              remaining_next = 2'(len - 2'd1);
            end
          end
        end
        MODE_DATA: begin
          if (held == 2'd3) begin
            mode_next      = MODE_IDLE;
            held_next      = 2'd0;
            remaining_next = 2'd0;
          end else begin
            store_next[held] = rx_byte;
            if (remaining > 2'd1) begin
              held_next      = 2'(held + 2'd1);
              remaining_next = 2'(remaining - 2'd1);
            end else begin
              remaining_next = 2'd0;
              count          = 2'(held + 2'd1);
              mode_next      = MODE_IDLE;
              held_next      = 2'd0;
              res_valid      = 1'b1;
            end
          end
        end
        MODE_SYSEX: begin
          if (rx_byte == SYSEX_END) begin
            mode_next      = MODE_IDLE;
            held_next      = 2'd0;
            remaining_next = 2'd0;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase
    end
    res.status_byte = store_next[0];
    res.first_data  = (count >= 2'd2) ? store_next[1] : 8'h00;
    res.second_data = (count >= 2'd3) ? store_next[2] : 8'h00;
    res.byte_count  = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      held      <= 2'd0;
      remaining <= 2'd0;
      running   <= 8'h00;
    end else if (fire) begin
      mode      <= mode_next;
      held      <= held_next;
      remaining <= remaining_next;
      running   <= running_next;
    end
  end

  // message store has no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      store <= store_next;
    end
  end

endmodule

// ===== src/mbsp_out_stage.sv =====
// result register that drives the message channel
module mbsp_out_stage import mbsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic       load_valid,
  input  msg_t       load_msg,
  output logic       space,
  mbsp_msg_if.source msg
);

  logic valid;
  msg_t data;

  assign space = !valid || msg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= load && load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load && load_valid) begin
      data <= load_msg;
    end
  end

  assign msg.valid       = valid;
  assign msg.status_byte = data.status_byte;
  assign msg.first_data  = data.first_data;
  assign msg.second_data = data.second_data;
  assign msg.byte_count  = data.byte_count;

endmodule

// ===== src/midi_byte_stream_parser_unit.sv =====
// midi byte stream parser with running status, top level
//
//   channel  dir  payload                                           request
//   rx       in   rx_byte                                           one byte
//   msg      out  status_byte, first_data, second_data, byte_count  one message
//
// a byte is registered in the input register, then the parser updates its
// state and loads the result register; one byte per cycle while msg is not stalled
// rst is synchronous and clears mode, counts, running status and valid flags
// a stalled msg channel holds the result register; rx keeps taking one more
// byte into the input register, then ready drops until msg is drained
`include "midi_byte_stream_parser_unit_defines.svh"

module midi_byte_stream_parser_unit import mbsp_pkg::*; (
  input logic        clk,
  input logic        rst,
  mbsp_byte_if.sink  rx,
  mbsp_msg_if.source msg
);

  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       space;
  logic       fire;
  logic       res_valid;
  msg_t       res;

  assign fire     = in_q_valid && space;
  assign rx.ready = !in_q_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (rx.ready) begin
      in_q_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_q_byte <= rx.rx_byte;
    end
  end

  mbsp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (in_q_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  mbsp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .load_valid (res_valid),
    .load_msg   (res),
    .space      (space),
    .msg        (msg)
  );

  `MBSP_ASSERT_NOW(a_msg_shape, msg.valid, msg.status_byte[7] && msg.byte_count != 2'd0, "bad message")
  `MBSP_ASSERT_NOW(a_short_zero, msg.valid && msg.byte_count == 2'd1, msg.first_data == 8'h00 && msg.second_data == 8'h00, "data on status-only message")
  `MBSP_ASSERT_NOW(a_full_stall, in_q_valid && msg.valid && !msg.ready, !rx.ready, "input taken while pipeline full")
  `MBSP_ASSERT_NEXT(a_hold_byte, in_q_valid && !space, in_q_valid && $stable(in_q_byte), "stalled byte lost")

endmodule

// ===== tb/sv/midi_byte_stream_parser_unit_tb.sv =====
// self-checking testbench for the midi byte stream parser unit
`timescale 1ns / 1ps

module midi_byte_stream_parser_unit_tb;
  import mbsp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 1600;
  localparam int HOLD_CYCLES  = 250;

  typedef struct {
    logic [7:0] rx_byte;
    bit         typed;
    bit         typed_out;
    msg_t       typed_msg;
  } step_row_t;

  logic clk;
  logic rst;

  mbsp_byte_if rx_ch ();
  mbsp_msg_if  msg_ch ();

  midi_byte_stream_parser_unit DUT (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .msg(msg_ch)
  );

  // parser state mirror
  mode_t      parse_state;
  logic [1:0] held_count;
  logic [1:0] data_left;
  logic [7:0] msg_store [3];
  logic [7:0] run_status;

  msg_t pending_msgs [$];
  int   mismatch_count;
  int   cycle_count;
  int   bytes_accepted;
  bit   quiet;
  bit   msg_hold;

  step_row_t directed_rows [29] = '{
    '{8'h45, 1, 0, '0},
    '{8'hF8, 1, 1, msg_t'{8'hF8, 8'h00, 8'h00, 2'd1}},
    '{8'hFE, 1, 0, '0},
    '{8'h90, 1, 0, '0},
    '{8'h3C, 1, 0, '0},
    '{8'h7F, 1, 1, msg_t'{8'h90, 8'h3C, 8'h7F, 2'd3}},
    '{8'h00, 0, 0, '0},
    '{8'h7F, 0, 0, '0},
    '{8'hC5, 1, 0, '0},
    '{8'h7F, 1, 1, msg_t'{8'hC5, 8'h7F, 8'h00, 2'd2}},
    '{8'h12, 0, 0, '0},
    '{8'hF0, 0, 0, '0},
    '{8'h90, 0, 0, '0},
    '{8'hF0, 0, 0, '0},
    '{8'hF7, 0, 0, '0},
    '{8'h33, 0, 0, '0},
    '{8'hF2, 0, 0, '0},
    '{8'h01, 0, 0, '0},
    '{8'hFE, 0, 0, '0},
    '{8'h02, 0, 0, '0},
    '{8'hF3, 0, 0, '0},
    '{8'h20, 0, 0, '0},
    '{8'hF7, 1, 1, msg_t'{8'hF7, 8'h00, 8'h00, 2'd1}},
    '{8'hE0, 0, 0, '0},
    '{8'h80, 0, 0, '0},
    '{8'hFF, 0, 0, '0},
    '{8'hFF, 1, 1, msg_t'{8'hFF, 8'h00, 8'h00, 2'd1}},
    '{8'hF1, 0, 0, '0},
    '{8'h00, 0, 0, '0}
  };

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  function automatic logic [1:0] data_bytes_for(input logic [7:0] status);
    return (status[6:4] == 3'd4 || status[6:4] == 3'd5) ? 2'd1 : 2'd2;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // advance the mirror by one byte, giving the message it completes if any
  task automatic parse_midi_byte(input logic [7:0] b, output bit produced,
                                 output msg_t done_msg);
    logic [1:0] len;
    produced = 1'b0;
    done_msg = '0;
    if (b == ACTIVE_SENSE) return;
    case (parse_state)
      MODE_IDLE: begin
        if (b[7]) begin
          if (b[7:4] == SYSTEM_NIB) begin
            if (b == SYSEX_START) begin
              parse_state = MODE_SYSEX;
            end else if (b == MTC_QF || b == SONG_SEL || b == SONG_POS) begin
              parse_state  = MODE_DATA;
              msg_store[0] = b;
              held_count   = 2'd1;
              data_left    = (b == SONG_POS) ? 2'd2 : 2'd1;
            end else begin
              msg_store[0] = b;
              held_count   = 2'd0;
              data_left    = 2'd0;
              produced     = 1'b1;
              done_msg     = msg_t'{b, 8'h00, 8'h00, 2'd1};
            end
          end else begin
            parse_state  = MODE_DATA;
            msg_store[0] = b;
            run_status   = b;
            held_count   = 2'd1;
            data_left    = data_bytes_for(b);
          end
        end else if (run_status[7]) begin
          len          = data_bytes_for(run_status);
          msg_store[0] = run_status;
          msg_store[1] = b;
          if (len == 2'd1) begin
            held_count = 2'd0;
            data_left  = 2'd0;
            produced   = 1'b1;
            done_msg   = msg_t'{run_status, b, 8'h00, 2'd2};
          end else begin
            parse_state = MODE_DATA;
            held_count  = 2'd2;
            data_left   = len - 2'd1;
          end
        end
      end
      MODE_DATA: begin
        msg_store[held_count] = b;
        held_count = held_count + 2'd1;
        if (data_left > 2'd1) begin
          data_left = data_left - 2'd1;
        end else begin
          data_left            = 2'd0;
          produced             = 1'b1;
          done_msg.status_byte = msg_store[0];
          done_msg.first_data  = (held_count >= 2'd2) ? msg_store[1] : 8'h00;
          done_msg.second_data = (held_count >= 2'd3) ? msg_store[2] : 8'h00;
          done_msg.byte_count  = held_count;
          parse_state          = MODE_IDLE;
          held_count           = 2'd0;
        end
      end
      MODE_SYSEX: begin
        if (b == SYSEX_END) begin
          parse_state = MODE_IDLE;
          held_count  = 2'd0;
          data_left   = 2'd0;
        end
      end
      default: parse_state = MODE_IDLE;
    endcase
  endtask

  // offer one byte, wait for the request to go through, then predict
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input bit typed_out = 1'b0, input msg_t typed_msg = '0);
    int   gap;
    bit   produced;
    msg_t next_msg;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    parse_midi_byte(b, produced, next_msg);
    if (typed) begin
      if (typed_out) pending_msgs.push_back(typed_msg);
    end else if (produced) begin
      pending_msgs.push_back(next_msg);
    end
    if (b != ACTIVE_SENSE) bytes_accepted++;
    quiet <= ((bytes_accepted >> 7) % 3 == 2);
  endtask

  task automatic send_data(input logic [1:0] len);
    repeat (len) begin
      if ($urandom_range(0, 15) == 0) send_byte(ACTIVE_SENSE);
      send_byte(8'($urandom_range(0, 127)));
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls, checks each accepted message
  always @(posedge clk) begin : msg_side
    int   nw;
    msg_t got;
    msg_t want;
    if (rst) begin
      msg_ch.ready <= 1'b0;
      nw = 0;
    end else begin
      if (msg_ch.valid && msg_ch.ready) begin
        got = msg_t'{msg_ch.status_byte, msg_ch.first_data, msg_ch.second_data,
                     msg_ch.byte_count};
        if (pending_msgs.size() == 0) begin
          flag_mismatch($sformatf("unexpected message %h %h %h count %0d",
                        got.status_byte, got.first_data, got.second_data,
                        got.byte_count));
        end else begin
          want = pending_msgs.pop_front();
          if (got.status_byte !== want.status_byte)
            flag_mismatch($sformatf("status_byte got %h want %h",
                          got.status_byte, want.status_byte));
          if (got.first_data !== want.first_data)
            flag_mismatch($sformatf("first_data got %h want %h",
                          got.first_data, want.first_data));
          if (got.second_data !== want.second_data)
            flag_mismatch($sformatf("second_data got %h want %h",
                          got.second_data, want.second_data));
          if (got.byte_count !== want.byte_count)
            flag_mismatch($sformatf("byte_count got %0d want %0d",
                          got.byte_count, want.byte_count));
        end
      end
      if (msg_hold) begin
        msg_ch.ready <= 1'b0;
      end else if (msg_ch.ready) begin
        if (msg_ch.valid) begin
          nw = quiet ? 0 : $urandom_range(0, 7);
          msg_ch.ready <= (nw == 0);
        end
      end else if (nw > 1) begin
        nw = nw - 1;
      end else begin
        msg_ch.ready <= 1'b1;
      end
    end
  end

  // long hold-off on the result side so the input backs up
  initial begin
    msg_hold = 1'b0;
    wait (bytes_accepted >= 400);
    @(posedge clk);
    msg_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    msg_hold <= 1'b0;
  end

  initial begin
    int         pick;
    logic [7:0] st;
    logic [7:0] b;
    rst            = 1'b1;
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = 8'h00;
    msg_ch.ready   = 1'b0;
    quiet          = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    bytes_accepted = 0;
    parse_state    = MODE_IDLE;
    held_count     = 2'd0;
    data_left      = 2'd0;
    run_status     = 8'h00;
    msg_store      = '{8'h00, 8'h00, 8'h00};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx_byte, directed_rows[i].typed,
                directed_rows[i].typed_out, directed_rows[i].typed_msg);

    while (bytes_accepted < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        st = 8'($urandom_range(8'h80, 8'hEF));
        send_byte(st);
        send_data(data_bytes_for(st));
        repeat ($urandom_range(0, 3)) send_data(data_bytes_for(st));
      end else if (pick < 57) begin
        case ($urandom_range(0, 2))
          0: st = MTC_QF;
          1: st = SONG_POS;
          default: st = SONG_SEL;
        endcase
        send_byte(st);
        send_data((st == SONG_POS) ? 2'd2 : 2'd1);
      end else if (pick < 67) begin
        send_byte(8'($urandom_range(8'hF4, 8'hFF)));
      end else if (pick < 75) begin
        send_byte(SYSEX_START);
        repeat ($urandom_range(0, 6)) begin
          do b = 8'($urandom); while (b == SYSEX_END);
          send_byte(b);
        end
        send_byte(SYSEX_END);
      end else if (pick < 88) begin
        // status byte lands inside an open message
        st = 8'($urandom_range(8'h80, 8'hEF));
        send_byte(st);
        send_byte(8'($urandom_range(8'h80, 8'hFF)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    rx_ch.valid <= 1'b0;

    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/mbsp_pkg.sv
src/mbsp_byte_if.sv
src/mbsp_msg_if.sv
src/mbsp_parse.sv
src/mbsp_out_stage.sv
src/midi_byte_stream_parser_unit.sv
tb/sv/midi_byte_stream_parser_unit_tb.sv
